FILE: src/ttelc_pkg.sv
// ----------------------------------------------------------------------------
// ttelc_pkg: shared types and constants of the tab expander / line counter
// Result kinds, character codes, register indexes and field widths.
// ----------------------------------------------------------------------------
package ttelc_pkg;

   localparam int BYTE_W        = 8;
   localparam int TAB_W         = 4;
   localparam int COL_W         = 10;
   localparam int KIND_W        = 2;
   localparam int LINE_TOTAL_W  = 24;
   localparam int CSR_INDEX_W   = 1;
   localparam int CSR_DATA_W    = 10;
   localparam int DIV_CNT_W     = 4;

   typedef logic [KIND_W-1:0] kind_type;
   typedef logic [BYTE_W-1:0] byte_type;
   typedef logic [COL_W-1:0]  col_type;
   typedef logic [TAB_W-1:0]  tab_type;

   localparam kind_type KIND_CHAR    = 2'd0;
   localparam kind_type KIND_EOL     = 2'd1;
   localparam kind_type KIND_SUMMARY = 2'd2;

   localparam byte_type CH_NUL   = 8'h00;
   localparam byte_type CH_TAB   = 8'h09;
   localparam byte_type CH_LF    = 8'h0A;
   localparam byte_type CH_CR    = 8'h0D;
   localparam byte_type CH_SPACE = 8'h20;

   localparam tab_type TAB_MAX        = 4'd9;
   localparam tab_type TAB_SIZE_RESET = 4'd8;
   localparam col_type MAX_WIDTH_RESET = 10'd272;

   localparam logic [CSR_INDEX_W-1:0] CSR_TAB_SIZE  = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_WIDTH = 1'd1;

endpackage

FILE: src/text_tab_expander_line_counter_top.sv
// ----------------------------------------------------------------------------
// text_tab_expander_line_counter_top: tab expander and line counter
// Streams text bytes in, expanded characters, line ends and a summary out.
// ----------------------------------------------------------------------------
// Usage:
//   req_*  : one text byte per beat, req_end_of_text on the final byte.
//   rsp_*  : result beats; rsp_kind tells a character, a line end with its
//            clamped width, or the end-of-text summary. rsp_last marks the
//            last beat caused by one request beat; a byte may cause none.
//   csr_*  : write tab_size (index 0) or max_width (index 1) while idle.
// Timing:
//   An ordinary byte passes decode, character and post back to idle; its
//   result is registered the cycle after it is formed. A tab (nonzero tab
//   size) runs a 10-step remainder of column by tab size through one shared
//   compare/subtract unit, then emits one space per cycle while the output
//   register is free. A CR or LF passes decode, line end and post; the LF
//   of a CR LF pair skips line end. The final byte adds an open line's end
//   and the summary. One byte at a time: req_ready is high only in idle.
// Reset:
//   Synchronous, active high; clears the line state and counters and loads
//   tab size 8 and maximum width 272. No clearing pass is needed.
// Stall:
//   A result beat waits in the output register; the sequencer holds until
//   that register is free, so nothing is lost when rsp_ready is low.
// ----------------------------------------------------------------------------
module text_tab_expander_line_counter_top
   import ttelc_pkg::*;
#(
   parameter int COUNT_BITS = 24
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [BYTE_W-1:0]      req_text_byte,
   input  logic                   req_end_of_text,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [KIND_W-1:0]      rsp_kind,
   output logic [BYTE_W-1:0]      rsp_out_char,
   output logic [COL_W-1:0]       rsp_line_width,
   output logic [LINE_TOTAL_W-1:0] rsp_line_total,
   output logic [COL_W-1:0]       rsp_widest_line,
   output logic                   rsp_last,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_DECODE = 3'd1;
   localparam logic [2:0] S_DIV    = 3'd2;
   localparam logic [2:0] S_TAB    = 3'd3;
   localparam logic [2:0] S_CHAR   = 3'd4;
   localparam logic [2:0] S_POST   = 3'd5;
   localparam logic [2:0] S_EOL    = 3'd6;
   localparam logic [2:0] S_SUM    = 3'd7;

   localparam logic [DIV_CNT_W-1:0] DIV_TOP = DIV_CNT_W'(COL_W - 1);

   logic [2:0]            state_ff, state_in;
   tab_type               tab_size_ff, tab_size_in;
   col_type               max_width_ff, max_width_in;
   col_type               column_ff, column_in;
   logic                  after_cr_ff, after_cr_in;
   logic                  line_open_ff, line_open_in;
   logic [COUNT_BITS-1:0] line_count_ff, line_count_in;
   col_type               max_columns_ff, max_columns_in;
   byte_type              byte_ff, byte_in;
   logic                  eot_ff, eot_in;
   logic [DIV_CNT_W-1:0]  div_cnt_ff, div_cnt_in;
   tab_type               rem_ff, rem_in;
   tab_type               k_ff, k_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   kind_type              rsp_kind_ff, rsp_kind_in;
   byte_type              rsp_char_ff, rsp_char_in;
   col_type               rsp_width_ff, rsp_width_in;
   logic [LINE_TOTAL_W-1:0] rsp_total_ff, rsp_total_in;
   col_type               rsp_widest_ff, rsp_widest_in;
   logic                  rsp_last_ff, rsp_last_in;

   tab_type               ts_eff;
   logic                  slot_free;
   logic                  room;
   col_type               clamp_w;
   logic [COUNT_BITS-1:0] count_inc;
   col_type               widest_inc;
   logic [TAB_W:0]        div_r, div_ts, div_sub;
   tab_type               rem_next;
   logic                  emit;
   kind_type              e_kind;
   byte_type              e_char;
   col_type               e_width;
   logic                  e_last;
   logic [COUNT_BITS-1:0] e_count;
   col_type               e_widest;
   logic [LINE_TOTAL_W-1:0] e_total;

   assign ts_eff     = (tab_size_ff > TAB_MAX) ? TAB_MAX : tab_size_ff;
   assign slot_free  = !rsp_valid_ff || rsp_ready;
   assign room       = column_ff < max_width_ff;
   assign clamp_w    = room ? column_ff : max_width_ff;
   assign count_inc  = (line_count_ff == {COUNT_BITS{1'b1}}) ? line_count_ff
                                                               : line_count_ff + 1'b1;
   assign widest_inc = (clamp_w > max_columns_ff) ? clamp_w : max_columns_ff;

   // one restoring remainder step per cycle, column MSB first
   assign div_r    = {rem_ff, column_ff[div_cnt_ff]};
   assign div_ts   = {1'b0, ts_eff};
   assign div_sub  = div_r - div_ts;
   assign rem_next = (div_r >= div_ts) ? div_sub[TAB_W-1:0] : div_r[TAB_W-1:0];

   generate
      if (COUNT_BITS >= LINE_TOTAL_W) begin : g_total_trunc
         assign e_total = e_count[LINE_TOTAL_W-1:0];
      end else begin : g_total_ext
         assign e_total = {{(LINE_TOTAL_W-COUNT_BITS){1'b0}}, e_count};
      end
   endgenerate

   always_comb begin
      state_in       = state_ff;
      tab_size_in    = tab_size_ff;
      max_width_in   = max_width_ff;
      column_in      = column_ff;
      after_cr_in    = after_cr_ff;
      line_open_in   = line_open_ff;
      line_count_in  = line_count_ff;
      max_columns_in = max_columns_ff;
      byte_in        = byte_ff;
      eot_in         = eot_ff;
      div_cnt_in     = div_cnt_ff;
      rem_in         = rem_ff;
      k_in           = k_ff;
      emit           = 1'b0;
      e_kind         = KIND_CHAR;
      e_char         = '0;
      e_width        = '0;
      e_last         = 1'b0;
      e_count        = line_count_ff;
      e_widest       = max_columns_ff;
      req_ready      = (state_ff == S_IDLE);

      if (csr_we) begin
         case (csr_index)
            CSR_TAB_SIZE:  tab_size_in  = csr_wdata[TAB_W-1:0];
            CSR_MAX_WIDTH: max_width_in = csr_wdata[COL_W-1:0];
            default: ;
         endcase
      end

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               byte_in  = req_text_byte;
               eot_in   = req_end_of_text;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            if (after_cr_ff && byte_ff == CH_LF) begin
               // LF of a CR LF pair: no result, no new line
               after_cr_in = 1'b0;
               state_in    = S_POST;
            end else if (byte_ff == CH_CR || byte_ff == CH_LF) begin
               after_cr_in = (byte_ff == CH_CR);
               state_in    = S_EOL;
            end else begin
               after_cr_in  = 1'b0;
               line_open_in = 1'b1;
               if (byte_ff == CH_TAB && ts_eff != '0) begin
                  div_cnt_in = DIV_TOP;
                  rem_in     = '0;
                  state_in   = S_DIV;
               end else begin
                  state_in = S_CHAR;
               end
            end
         end
         S_DIV: begin
            rem_in     = rem_next;
            div_cnt_in = div_cnt_ff - 1'b1;
            if (div_cnt_ff == '0) begin
               k_in     = ts_eff - rem_next;
               state_in = S_TAB;
            end
         end
         S_TAB: begin
            if (k_ff == '0 || !room) begin
               state_in = S_POST;
            end else if (slot_free) begin
               emit      = 1'b1;
               e_char    = CH_SPACE;
               e_last    = !eot_ff && (k_ff == 4'd1 || column_ff + 1'b1 >= max_width_ff);
               column_in = column_ff + 1'b1;
               k_in      = k_ff - 1'b1;
            end
         end
         S_CHAR: begin
            if (!room) begin
               state_in = S_POST;
            end else if (slot_free) begin
               emit      = 1'b1;
               e_char    = (byte_ff == CH_NUL) ? CH_SPACE : byte_ff;
               e_last    = !eot_ff;
               column_in = column_ff + 1'b1;
               state_in  = S_POST;
            end
         end
         S_POST: begin
            if (!eot_ff) begin
               state_in = S_IDLE;
            end else if (line_open_ff) begin
               state_in = S_EOL;
            end else begin
               state_in = S_SUM;
            end
         end
         S_EOL: begin
            if (slot_free) begin
               emit           = 1'b1;
               e_kind         = KIND_EOL;
               e_width        = clamp_w;
               e_last         = !eot_ff;
               e_count        = count_inc;
               e_widest       = widest_inc;
               line_count_in  = count_inc;
               max_columns_in = widest_inc;
               column_in      = '0;
               line_open_in   = 1'b0;
               state_in       = S_POST;
            end
         end
         S_SUM: begin
            if (slot_free) begin
               emit           = 1'b1;
               e_kind         = KIND_SUMMARY;
               e_last         = 1'b1;
               // start over for the next text
               column_in      = '0;
               after_cr_in    = 1'b0;
               line_open_in   = 1'b0;
               line_count_in  = '0;
               max_columns_in = '0;
               state_in       = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_kind_in   = rsp_kind_ff;
      rsp_char_in   = rsp_char_ff;
      rsp_width_in  = rsp_width_ff;
      rsp_total_in  = rsp_total_ff;
      rsp_widest_in = rsp_widest_ff;
      rsp_last_in   = rsp_last_ff;
      if (emit) begin
         rsp_valid_in  = 1'b1;
         rsp_kind_in   = e_kind;
         rsp_char_in   = e_char;
         rsp_width_in  = e_width;
         rsp_total_in  = e_total;
         rsp_widest_in = e_widest;
         rsp_last_in   = e_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         tab_size_ff    <= TAB_SIZE_RESET;
         max_width_ff   <= MAX_WIDTH_RESET;
         column_ff      <= '0;
         after_cr_ff    <= 1'b0;
         line_open_ff   <= 1'b0;
         line_count_ff  <= '0;
         max_columns_ff <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         tab_size_ff    <= tab_size_in;
         max_width_ff   <= max_width_in;
         column_ff      <= column_in;
         after_cr_ff    <= after_cr_in;
         line_open_ff   <= line_open_in;
         line_count_ff  <= line_count_in;
         max_columns_ff <= max_columns_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff       <= byte_in;
      eot_ff        <= eot_in;
      div_cnt_ff    <= div_cnt_in;
      rem_ff        <= rem_in;
      k_ff          <= k_in;
      rsp_kind_ff   <= rsp_kind_in;
      rsp_char_ff   <= rsp_char_in;
      rsp_width_ff  <= rsp_width_in;
      rsp_total_ff  <= rsp_total_in;
      rsp_widest_ff <= rsp_widest_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_kind        = rsp_kind_ff;
   assign rsp_out_char    = rsp_char_ff;
   assign rsp_line_width  = rsp_width_ff;
   assign rsp_line_total  = rsp_total_ff;
   assign rsp_widest_line = rsp_widest_ff;
   assign rsp_last        = rsp_last_ff;

endmodule

FILE: src/ttelc_checker.sv
// ----------------------------------------------------------------------------
// ttelc_checker: port-level checks for the tab expander / line counter
// Watches the request and result channels and flags broken beats.
// ----------------------------------------------------------------------------
module ttelc_checker
   import ttelc_pkg::*;
(
   input logic                    clock,
   input logic                    reset,
   input logic                    req_valid,
   input logic                    req_ready,
   input logic                    rsp_valid,
   input logic                    rsp_ready,
   input logic [KIND_W-1:0]       rsp_kind,
   input logic [COL_W-1:0]        rsp_line_width,
   input logic [COL_W-1:0]        rsp_widest_line,
   input logic                    rsp_last
);

   // a stalled result beat stays valid and holds its kind and last flag
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_kind) && $stable(rsp_last))
      else $error("result beat changed while stalled");

   // one byte at a time: busy right after a request beat
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while previous byte in progress");

   a_sum_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == KIND_SUMMARY |-> rsp_last)
      else $error("summary beat not marked last");

   a_widest: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == KIND_EOL |-> rsp_widest_line >= rsp_line_width)
      else $error("widest line below finished line width");

   a_width_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind != KIND_EOL |-> rsp_line_width == '0)
      else $error("line width set on a non line-end beat");

endmodule

bind text_tab_expander_line_counter_top ttelc_checker u_ttelc_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_ready       (req_ready),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_kind        (rsp_kind),
   .rsp_line_width  (rsp_line_width),
   .rsp_widest_line (rsp_widest_line),
   .rsp_last        (rsp_last)
);
